// File: rtl/core/qrv_pkg.sv
// ----------------------------------------------------------------------------
// qrv_pkg
// Shared widths and word types for the quaternion vector rotation block.
// ----------------------------------------------------------------------------
package qrv_pkg;

   localparam int VEC_BITS  = 24;
   localparam int QUAT_BITS = 16;

   typedef struct packed {
      logic signed [QUAT_BITS-1:0] quat_w;
      logic signed [QUAT_BITS-1:0] quat_x;
      logic signed [QUAT_BITS-1:0] quat_y;
      logic signed [QUAT_BITS-1:0] quat_z;
      logic signed [VEC_BITS-1:0]  vec_x;
      logic signed [VEC_BITS-1:0]  vec_y;
      logic signed [VEC_BITS-1:0]  vec_z;
   } qrv_req_type;

   typedef struct packed {
      logic signed [VEC_BITS-1:0] rot_x;
      logic signed [VEC_BITS-1:0] rot_y;
      logic signed [VEC_BITS-1:0] rot_z;
      logic                       zero_quat;
      logic                       clipped;
   } qrv_rsp_type;

endpackage

// File: rtl/core/quaternion_rotate_vector.sv
// ----------------------------------------------------------------------------
// quaternion_rotate_vector
// Rotates a 3D vector by a quaternion normalized through one rounded division.
// ----------------------------------------------------------------------------
// The block takes one word per cycle until a stall on the result side backs
// up to the input. The restoring divider settles one quotient bit per
// pipeline stage; the multiplies and adds ahead of it take six stages and
// rounding and saturation three more. Stalls on the result side are
// absorbed by empty stages first, so bubbles close up before the input is
// held off. A zero quaternion passes the vector through with zero_quat set.
module quaternion_rotate_vector (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  qrv_pkg::qrv_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output qrv_pkg::qrv_rsp_type rsp_data
);
   import qrv_pkg::*;

   localparam int VB     = VEC_BITS;
   localparam int QB     = QUAT_BITS;
   localparam int P_W    = QB + VB;
   localparam int C_W    = P_W + 1;
   localparam int SQ_W   = 2 * QB;
   localparam int N2_W   = 2 * QB + 1;
   localparam int P2_W   = QB + C_W;
   localparam int D_W    = P2_W + 1;
   localparam int NUM_W  = D_W + 2;
   localparam int Q_W    = VB + 1;
   localparam int R_W    = VB + 2;
   localparam int S_W    = VB + 4;
   localparam int CMP_W  = (NUM_W > N2_W + Q_W) ? NUM_W : N2_W + Q_W;
   localparam int DIV0   = 6;
   localparam int RND1   = DIV0 + Q_W;
   localparam int RND2   = RND1 + 1;
   localparam int NST    = RND2 + 2;

   typedef struct packed {
      logic [2:0][VB-1:0] v;
      logic [N2_W-1:0]    n2;
      logic [2:0]         neg;
      logic               zero;
   } side_type;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic [NST-1:0] en;

   // A stage may load when it is empty or when its contents move on.
   assign en[NST-1] = !vld_ff[NST-1] || rsp_ready;
   for (genvar k = 0; k < NST - 1; k++) begin : g_en
      assign en[k] = !vld_ff[k] || en[k+1];
   end

   assign vld_in = {vld_ff[NST-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= (vld_ff & ~en) | (vld_in & en);
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[NST-1];

   // Stage 0: first cross product terms and squares.
   logic signed [P_W-1:0]  p_ff  [6];
   logic signed [SQ_W-1:0] sq_ff [4];
   logic signed [QB-1:0]   q0_ff [4];
   logic [2:0][VB-1:0]     v0_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p_ff[0]  <= P_W'(req_data.quat_y) * P_W'(req_data.vec_z);
         p_ff[1]  <= P_W'(req_data.quat_z) * P_W'(req_data.vec_y);
         p_ff[2]  <= P_W'(req_data.quat_z) * P_W'(req_data.vec_x);
         p_ff[3]  <= P_W'(req_data.quat_x) * P_W'(req_data.vec_z);
         p_ff[4]  <= P_W'(req_data.quat_x) * P_W'(req_data.vec_y);
         p_ff[5]  <= P_W'(req_data.quat_y) * P_W'(req_data.vec_x);
         sq_ff[0] <= SQ_W'(req_data.quat_w) * SQ_W'(req_data.quat_w);
         sq_ff[1] <= SQ_W'(req_data.quat_x) * SQ_W'(req_data.quat_x);
         sq_ff[2] <= SQ_W'(req_data.quat_y) * SQ_W'(req_data.quat_y);
         sq_ff[3] <= SQ_W'(req_data.quat_z) * SQ_W'(req_data.quat_z);
         q0_ff[0] <= req_data.quat_w;
         q0_ff[1] <= req_data.quat_x;
         q0_ff[2] <= req_data.quat_y;
         q0_ff[3] <= req_data.quat_z;
         v0_ff    <= {req_data.vec_z, req_data.vec_y, req_data.vec_x};
      end
   end

   side_type side_ff [1:NST-2];

   // Stage 1: cross product c = u x v and the squared norm.
   logic signed [C_W-1:0] c_ff  [3];
   logic signed [QB-1:0]  q1_ff [4];
   logic [N2_W-1:0]       n2_in;

   assign n2_in = N2_W'(sq_ff[0]) + N2_W'(sq_ff[1]) + N2_W'(sq_ff[2]) + N2_W'(sq_ff[3]);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         c_ff[0]         <= C_W'(p_ff[0]) - C_W'(p_ff[1]);
         c_ff[1]         <= C_W'(p_ff[2]) - C_W'(p_ff[3]);
         c_ff[2]         <= C_W'(p_ff[4]) - C_W'(p_ff[5]);
         q1_ff           <= q0_ff;
         side_ff[1].v    <= v0_ff;
         side_ff[1].n2   <= n2_in;
         side_ff[1].neg  <= '0;
         side_ff[1].zero <= (n2_in == '0);
      end
   end

   // Stage 2: second cross product terms and w times c.
   logic signed [P2_W-1:0] e_ff  [6];
   logic signed [P2_W-1:0] wc_ff [3];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         e_ff[0]    <= P2_W'(q1_ff[2]) * P2_W'(c_ff[2]);
         e_ff[1]    <= P2_W'(q1_ff[3]) * P2_W'(c_ff[1]);
         e_ff[2]    <= P2_W'(q1_ff[3]) * P2_W'(c_ff[0]);
         e_ff[3]    <= P2_W'(q1_ff[1]) * P2_W'(c_ff[2]);
         e_ff[4]    <= P2_W'(q1_ff[1]) * P2_W'(c_ff[1]);
         e_ff[5]    <= P2_W'(q1_ff[2]) * P2_W'(c_ff[0]);
         for (int i = 0; i < 3; i++) begin
            wc_ff[i] <= P2_W'(q1_ff[0]) * P2_W'(c_ff[i]);
         end
         side_ff[2] <= side_ff[1];
      end
   end

   // Stage 3: d = u x c.
   logic signed [D_W-1:0]  d_ff   [3];
   logic signed [P2_W-1:0] wc3_ff [3];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         d_ff[0]    <= D_W'(e_ff[0]) - D_W'(e_ff[1]);
         d_ff[1]    <= D_W'(e_ff[2]) - D_W'(e_ff[3]);
         d_ff[2]    <= D_W'(e_ff[4]) - D_W'(e_ff[5]);
         wc3_ff     <= wc_ff;
         side_ff[3] <= side_ff[2];
      end
   end

   // Stage 4: numerator 2(wc + d).
   logic signed [NUM_W-1:0] num_ff [3];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         for (int i = 0; i < 3; i++) begin
            num_ff[i] <= {(NUM_W-1)'(wc3_ff[i]) + (NUM_W-1)'(d_ff[i]), 1'b0};
         end
         side_ff[4] <= side_ff[3];
      end
   end

   // Stage 5: sign and magnitude for the divider.
   logic [NUM_W-1:0] mag_ff [3];
   side_type         side5_in;

   always_comb begin
      side5_in = side_ff[4];
      for (int i = 0; i < 3; i++) begin
         side5_in.neg[i] = num_ff[i][NUM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         side_ff[5] <= side5_in;
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= side5_in.neg[i] ? NUM_W'(-num_ff[i]) : NUM_W'(num_ff[i]);
         end
      end
   end

   // Restoring divider: stage j decides quotient bit Q_W-1-j.
   logic [NUM_W-1:0] rem_ff [Q_W][3];
   logic [Q_W-1:0]   quo_ff [Q_W][3];

   for (genvar j = 0; j < Q_W; j++) begin : g_div
      logic [NUM_W-1:0] rem_src [3];
      logic [Q_W-1:0]   quo_src [3];
      side_type         side_src;
      logic [CMP_W-1:0] dvs;

      if (j == 0) begin : g_first
         assign rem_src  = mag_ff;
         assign side_src = side_ff[DIV0-1];
         for (genvar i = 0; i < 3; i++) begin : g_q
            assign quo_src[i] = '0;
         end
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign quo_src  = quo_ff[j-1];
         assign side_src = side_ff[DIV0+j-1];
      end

      assign dvs = CMP_W'(side_src.n2) << (Q_W - 1 - j);

      always_ff @(posedge clock) begin
         if (en[DIV0+j]) begin
            side_ff[DIV0+j] <= side_src;
            for (int i = 0; i < 3; i++) begin
               if (CMP_W'(rem_src[i]) >= dvs) begin
                  rem_ff[j][i] <= NUM_W'(CMP_W'(rem_src[i]) - dvs);
                  quo_ff[j][i] <= {quo_src[i][Q_W-2:0], 1'b1};
               end else begin
                  rem_ff[j][i] <= rem_src[i];
                  quo_ff[j][i] <= {quo_src[i][Q_W-2:0], 1'b0};
               end
            end
         end
      end
   end

   // Rounding to nearest, ties away from zero, then the sign goes back on.
   logic signed [R_W:0] qs_ff [3];
   logic [R_W-1:0]      qr_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qr_in[i] = R_W'(quo_ff[Q_W-1][i])
                  + R_W'({rem_ff[Q_W-1][i][N2_W-1:0], 1'b0} >= (N2_W+1)'(side_ff[RND1-1].n2));
      end
   end

   always_ff @(posedge clock) begin
      if (en[RND1]) begin
         side_ff[RND1] <= side_ff[RND1-1];
         for (int i = 0; i < 3; i++) begin
            qs_ff[i] <= side_ff[RND1-1].neg[i] ? -$signed({1'b0, qr_in[i]})
                                               : $signed({1'b0, qr_in[i]});
         end
      end
   end

   logic signed [S_W-1:0] sum_ff [3];

   always_ff @(posedge clock) begin
      if (en[RND2]) begin
         side_ff[RND2] <= side_ff[RND1];
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= S_W'($signed(side_ff[RND1].v[i])) + S_W'(qs_ff[i]);
         end
      end
   end

   // Output stage: saturation, or the vector as it came for a zero norm.
   localparam logic signed [S_W-1:0] VMAX = S_W'((64'sd1 <<< (VB - 1)) - 64'sd1);
   localparam logic signed [S_W-1:0] VMIN = -VMAX - S_W'(1);

   logic [2:0][VB-1:0] sat_in;
   logic [2:0]         clip_in;
   qrv_rsp_type        out_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (sum_ff[i] > VMAX) begin
            sat_in[i]  = VMAX[VB-1:0];
            clip_in[i] = 1'b1;
         end else if (sum_ff[i] < VMIN) begin
            sat_in[i]  = VMIN[VB-1:0];
            clip_in[i] = 1'b1;
         end else begin
            sat_in[i]  = sum_ff[i][VB-1:0];
            clip_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[NST-1]) begin
         if (side_ff[RND2].zero) begin
            out_ff.rot_x     <= side_ff[RND2].v[0];
            out_ff.rot_y     <= side_ff[RND2].v[1];
            out_ff.rot_z     <= side_ff[RND2].v[2];
            out_ff.zero_quat <= 1'b1;
            out_ff.clipped   <= 1'b0;
         end else begin
            out_ff.rot_x     <= sat_in[0];
            out_ff.rot_y     <= sat_in[1];
            out_ff.rot_z     <= sat_in[2];
            out_ff.zero_quat <= 1'b0;
            out_ff.clipped   <= |clip_in;
         end
      end
   end

   assign rsp_data = out_ff;

endmodule

// File: rtl/core/qrv_checker.sv
// ----------------------------------------------------------------------------
// qrv_checker
// Port-level checks for the quaternion vector rotation block.
// ----------------------------------------------------------------------------
module qrv_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input qrv_pkg::qrv_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input qrv_pkg::qrv_rsp_type rsp_data
);
   import qrv_pkg::*;

   // A held result word stays put until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // When the output is free, the input is never held off.
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input held off with a free output");

   // A zero quaternion passes the vector through and never saturates.
   a_zero_noclip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_quat |-> !rsp_data.clipped)
      else $error("zero quaternion result flagged as clipped");

endmodule

bind quaternion_rotate_vector qrv_checker u_qrv_checker (.*);
